/* design/sbr_pkg.sv */
// sbr_pkg: shared types and constants of the serial byte receiver
// no dependencies; imported by the core, config block, skid queue and top level

package sbr_pkg;

  // frame receive phases
  typedef enum logic [1:0] {
    PH_SETTLE = 2'd0,
    PH_ARMED  = 2'd1,
    PH_DATA   = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  localparam int unsigned DATA_BITS     = 8;
  localparam int unsigned ARM_THRESHOLD = 3;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned SLOT_IDX_W    = 4;
  localparam int unsigned FLAGS_W       = 32;
  localparam int unsigned IDLE_W        = 3;
  localparam int unsigned BITCNT_W      = 4;

  // input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // apb register map
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic        REG_NOTIFY  = 1'b0;

  localparam logic [FLAGS_W-1:0] NOTIFY_RESET = 32'd1;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0]     received_byte;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [FLAGS_W-1:0]    notify_flags;
  } res_t;

endpackage

/* design/sbr_in_if.sv */
// sbr_in_if: input channel carrying line events (tick or pin change)
// depends on nothing

interface sbr_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic pin_level;

  modport source (output valid, output cmd, output pin_level, input ready);
  modport sink   (input valid, input cmd, input pin_level, output ready);
endinterface

/* design/sbr_out_if.sv */
// sbr_out_if: output channel carrying received bytes
// depends on nothing

interface sbr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  received_byte;
  logic [3:0]  slot_index;
  logic [31:0] notify_flags;

  modport source (output valid, output received_byte, output slot_index,
                  output notify_flags, input ready);
  modport sink   (input valid, input received_byte, input slot_index,
                  input notify_flags, output ready);
endinterface

/* design/serial_byte_receiver.sv */
// serial_byte_receiver: top level of the 8n1 serial byte receiver
// depends on sbr_pkg, sbr_in_if, sbr_out_if, sbr_cfg, sbr_core, sbr_skid
//
//   channel  dir  handshake              beat contents
//   in_ch    in   valid/ready            cmd, pin_level
//   out_ch   out  valid/ready            received_byte, slot_index, notify_flags
//   apb      in   psel/penable, pready   notify_mask at paddr 0 to 3
//
// one event per cycle sustained while in_ch is not stalled; an event is
// registered, then the frame state machine updates and any byte is pushed
// into a two-entry queue at the same clock edge, and out_ch shows the queue head.
// synchronous reset returns the receiver to settling with notify_mask = 1;
// the byte ring holds no reset value and needs no clearing pass.
// in_ch stalls only when the result queue is full and an event waits in the input register.

module serial_byte_receiver import sbr_pkg::*; #(
  parameter int unsigned BUFFER_SIZE = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  sbr_in_if.sink                in_ch,
  sbr_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [FLAGS_W-1:0] notify_mask;
  logic               res_room;
  logic               res_valid;
  res_t               res;
  logic               res_push;

  // configuration registers
  sbr_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .notify_mask (notify_mask)
  );

  // frame receiver
  sbr_core #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .notify_mask (notify_mask),
    .res_room    (res_room),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign res_push = res_valid && res_room;

  // result queue
  sbr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .room      (res_room),
    .out_ch    (out_ch)
  );

endmodule

/* design/sbr_ram.sv */
// sbr_ram: generic single write port ram with registered read
// no dependencies

module sbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/sbr_cfg.sv */
// sbr_cfg: apb register block holding the notify mask
// depends on sbr_pkg

module sbr_cfg import sbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [FLAGS_W-1:0]    notify_mask
);

  logic reg_sel;
  logic wr_en;

  // register select is the top address bit
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_NOTIFY);
  assign wr_en   = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;

  // notify mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      notify_mask <= NOTIFY_RESET;
    end else if (wr_en) begin
      notify_mask <= pwdata;
    end
  end

  // read back, unmapped words read as zero
  assign prdata = reg_sel ? notify_mask : '0;

endmodule

/* design/sbr_core.sv */
// sbr_core: input register, frame state machine and ring write
// depends on sbr_pkg, sbr_in_if and sbr_ram

module sbr_core import sbr_pkg::*; #(
  parameter int unsigned BUFFER_SIZE = 16
) (
  input  logic               clk,
  input  logic               rst,
  sbr_in_if.sink             in_ch,
  input  logic [FLAGS_W-1:0] notify_mask,
  input  logic               res_room,
  output logic               res_valid,
  output res_t               res
);

  localparam int unsigned SLOT_W = $clog2(BUFFER_SIZE);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUFFER_SIZE - 1);

  // input register
  logic s_valid;
  logic s_cmd;
  logic s_level;
  logic fire;

  // receiver state
  phase_t              phase, phase_next;
  logic [IDLE_W-1:0]   idle_count, idle_count_next;
  logic [BITCNT_W-1:0] bit_count, bit_count_next;
  logic [BYTE_W-1:0]   shift_byte, shift_byte_next;
  logic [SLOT_W-1:0]   write_slot, write_slot_next;
  logic [SLOT_W-1:0]   last_slot;
  logic                wr_en;
  logic [BYTE_W-1:0]   ring_rdata;

  assign fire        = s_valid && res_room;
  assign in_ch.ready = !s_valid || res_room;

  // input register, one event per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s_cmd   <= in_ch.cmd;
      s_level <= in_ch.pin_level;
    end
  end

  // next state
  always_comb begin
    logic [IDLE_W-1:0]   idle_inc;
    logic [BITCNT_W-1:0] bit_inc;
    idle_inc        = idle_count + IDLE_W'(1);
    bit_inc         = bit_count + BITCNT_W'(1);
    phase_next      = phase;
    idle_count_next = idle_count;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    write_slot_next = write_slot;
    case (phase)
      PH_SETTLE: begin
        // count consecutive high ticks before arming
        if (s_cmd == CMD_TICK) begin
          if (!s_level) begin
            idle_count_next = '0;
          end else begin
            idle_count_next = idle_inc;
            if (idle_inc > IDLE_W'(ARM_THRESHOLD)) begin
              phase_next = PH_ARMED;
            end
          end
        end
      end
      PH_ARMED: begin
        // falling edge opens a frame
        if (s_cmd == CMD_EDGE && !s_level) begin
          phase_next      = PH_DATA;
          bit_count_next  = '0;
          shift_byte_next = '0;
        end
      end
      PH_DATA: begin
        // data bits, lsb first
        if (s_cmd == CMD_TICK) begin
          shift_byte_next = shift_byte | (BYTE_W'(s_level) << bit_count[2:0]);
          bit_count_next  = bit_inc;
          if (bit_inc >= BITCNT_W'(DATA_BITS)) begin
            phase_next = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        // stop bit tick closes the frame
        if (s_cmd == CMD_TICK) begin
          write_slot_next = (write_slot == SLOT_LAST) ? '0 : write_slot + SLOT_W'(1);
          phase_next      = PH_ARMED;
          idle_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_SETTLE;
      end
    endcase
  end

  // result and ring write
  always_comb begin
    res_valid         = s_valid && (phase == PH_STOP) && (s_cmd == CMD_TICK);
    res.received_byte = shift_byte;
    res.slot_index    = SLOT_IDX_W'(write_slot);
    res.notify_flags  = notify_mask;
    wr_en             = fire && res_valid;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SETTLE;
      idle_count <= '0;
      bit_count  <= '0;
      shift_byte <= '0;
      write_slot <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      idle_count <= idle_count_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      write_slot <= write_slot_next;
    end
  end

  // slot of the most recent write, read back for checking
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_slot <= write_slot;
    end
  end

  sbr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (write_slot),
    .wdata (shift_byte),
    .raddr (last_slot),
    .rdata (ring_rdata)
  );

  // settle count never passes the arming point
  a_idle_bound: assert property (@(posedge clk) disable iff (rst)
    idle_count <= IDLE_W'(ARM_THRESHOLD + 1))
    else $error("idle count beyond arming point");

  // bit count stays below a byte while shifting
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bit_count < BITCNT_W'(DATA_BITS))
    else $error("bit count overrun in data phase");

  // stop phase only after a full byte
  a_stop_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STOP |-> bit_count == BITCNT_W'(DATA_BITS))
    else $error("stop phase entered without a full byte");

  // a byte written to the ring reads back from its slot
  a_ring_readback: assert property (@(posedge clk) disable iff (rst)
    $past(wr_en, 2) && !$past(wr_en, 1) |-> ring_rdata == $past(shift_byte, 2))
    else $error("ring readback mismatch");

endmodule

/* design/sbr_skid.sv */
// sbr_skid: two-entry result queue decoupling the core from the output beat
// depends on sbr_pkg and sbr_out_if

module sbr_skid import sbr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  res_t     push_data,
  output logic     room,
  sbr_out_if.source out_ch
);

  res_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  res_t       head;

  assign room = (count != 2'd2);
  assign pop  = out_ch.valid && out_ch.ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // head of queue drives the output beat
  always_comb begin
    head                 = entry[rd_ptr];
    out_ch.valid         = (count != 2'd0);
    out_ch.received_byte = head.received_byte;
    out_ch.slot_index    = head.slot_index;
    out_ch.notify_flags  = head.notify_flags;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not follow push");

endmodule
